// ----- design/lpht_pkg.sv -----
// types, constants and helpers shared by the linear probe hash table unit
package lpht_pkg;

    // table size must stay a power of two: the home slot is the low key bits
    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int KEY_W      = 31;
    localparam int POS_W      = 4;
    localparam int EXT_W      = (IDX_W > POS_W) ? IDX_W : POS_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [POS_W-1:0] position;
    } out_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic hash;
        logic step;
        logic commit;
        logic fail;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic last;
    } dp_stat_t;

    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(idx);
        return ext[POS_W-1:0];
    endfunction

endpackage

// ----- design/lpht_dp.sv -----
// datapath: slot storage, probe index, probe counter and result register
module lpht_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  lpht_pkg::in_t    cmd,
    input  lpht_pkg::dp_cmd_t ctl,
    output lpht_pkg::dp_stat_t stat,
    output lpht_pkg::out_t   result
);
    import lpht_pkg::*;

    logic [KEY_W-1:0]      slot_key_reg [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] slot_used_reg;
    logic [TABLE_SIZE-1:0] slot_used_next;
    logic [1:0]            op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;
    logic [IDX_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      cnt_next;
    out_t                  result_reg;
    out_t                  result_next;
    logic                  is_insert;
    logic                  used_here;
    logic                  key_match;

    assign is_insert = (op_reg == OP_INSERT);
    assign used_here = slot_used_reg[idx_reg];
    assign key_match = used_here && (slot_key_reg[idx_reg] == key_reg);

    assign stat.hit  = is_insert ? !used_here : key_match;
    assign stat.last = (cnt_reg == IDX_W'(TABLE_SIZE - 1));

    always_comb
    begin
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        slot_used_next = slot_used_reg;
        result_next    = result_reg;
        if (ctl.hash)
        begin
            idx_next = key_reg[IDX_W-1:0];
            cnt_next = '0;
        end
        else if (ctl.step)
        begin
            // forward probe with wrap at the end of the table
            idx_next = (idx_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_reg + 1'b1;
            cnt_next = cnt_reg + 1'b1;
        end
        if (ctl.commit)
        begin
            if (is_insert)
            begin
                slot_used_next[idx_reg] = 1'b1;
            end
            else if (op_reg == OP_DELETE)
            begin
                slot_used_next[idx_reg] = 1'b0;
            end
            result_next.status   = ST_OK;
            result_next.position = to_pos(idx_reg);
        end
        else if (ctl.fail)
        begin
            result_next.status   = is_insert ? ST_FULL : ST_MISSING;
            result_next.position = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg <= '0;
        end
        else
        begin
            slot_used_reg <= slot_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= cmd.opcode;
            key_reg <= cmd.key;
        end
        if (ctl.commit && is_insert)
        begin
            slot_key_reg[idx_reg] <= key_reg;
        end
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- design/lpht_ctrl.sv -----
// controller: sequences hash, probe and response for one transaction
module lpht_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  lpht_pkg::dp_stat_t stat,
    output lpht_pkg::dp_cmd_t  ctl,
    output logic               busy,
    output logic               done
);
    import lpht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                ctl.hash   = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                priority if (stat.hit)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_RESP;
                end
                else if (stat.last)
                begin
                    ctl.fail   = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            S_RESP:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_one_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.commit && ctl.fail))
        else $error("commit and fail in the same cycle");

    a_finish_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.commit || ctl.fail) |=> done)
        else $error("finished probe not followed by result strobe");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    a_accept_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ctl.hash && busy)
        else $error("accepted transaction not hashed next cycle");
`endif

endmodule

// ----- design/linear_probe_hash_table_unit.sv -----
// top level of the linear probe hash table unit
// One transaction at a time: a command is taken when start is high and busy
// is low, and its result appears on result with done high for exactly one
// cycle; the receiver cannot stall, so it must capture result whenever done
// is high. After a command is taken, the controller hashes the key, then
// the probe loop reads one slot per cycle over 1 to 16 slots, and then the
// result is registered and shown. Insert stops at the first free slot,
// delete and search at the first matching key, else after all 16 slots.
// busy is low again in the cycle after done. Reset empties the table at
// once, with no clearing pass.
module linear_probe_hash_table_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lpht_pkg::in_t  cmd,
    output logic           done,
    output lpht_pkg::out_t result
);
    import lpht_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    lpht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    lpht_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .stat   (stat),
        .result (result)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the linear probe hash table unit
module testbench;

    import lpht_pkg::*;

    // opcode 3 is not a defined operation and behaves as a search
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 625;
    localparam int DRAIN_CYCLES = 24;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  cmd = '0;
    logic busy;
    logic done;
    out_t result;

    in_t  pending_cmds[$];
    out_t awaited_results[$];
    logic [KEY_W-1:0] live_keys[$];

    // table contents as predicted from the accepted transactions
    logic [KEY_W-1:0] table_key[TABLE_SIZE];
    bit               table_used[TABLE_SIZE];

    int unsigned total_items = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned insert_count = 0;
    int unsigned full_count = 0;
    int unsigned delete_count = 0;
    int unsigned search_count = 0;
    int unsigned missing_count = 0;

    linear_probe_hash_table_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #2 clk = ~clk;

    // applies one command to the predicted table and returns its outcome
    function automatic out_t hash_table_apply(input in_t c);
        out_t r;
        int   idx;
        int   n;
        bit   settled;
        r.status   = ST_MISSING;
        r.position = '0;
        settled    = 1'b0;
        idx = int'({1'b0, c.key} % TABLE_SIZE);
        if (c.opcode == OP_INSERT)
        begin
            insert_count++;
            r.status = ST_FULL;
            for (n = 0; n < TABLE_SIZE && !settled; n++)
            begin
                if (!table_used[idx])
                begin
                    table_key[idx]  = c.key;
                    table_used[idx] = 1'b1;
                    r.status   = ST_OK;
                    r.position = POS_W'(idx);
                    settled    = 1'b1;
                end
                else
                    idx = (idx + 1) % TABLE_SIZE;
            end
            if (!settled)
                full_count++;
        end
        else
        begin
            if (c.opcode == OP_DELETE)
                delete_count++;
            else
                search_count++;
            // no early stop at an empty slot: probing goes on until a match or all slots
            for (n = 0; n < TABLE_SIZE && !settled; n++)
            begin
                if (table_used[idx] && table_key[idx] == c.key)
                begin
                    if (c.opcode == OP_DELETE)
                        table_used[idx] = 1'b0;
                    r.status   = ST_OK;
                    r.position = POS_W'(idx);
                    settled    = 1'b1;
                end
                else
                    idx = (idx + 1) % TABLE_SIZE;
            end
            if (!settled)
                missing_count++;
        end
        return r;
    endfunction

    // queues a command and tracks which keys the table will hold
    task automatic queue_cmd(input logic [1:0] op, input logic [KEY_W-1:0] k);
        in_t c;
        int  i;
        c.opcode = op;
        c.key    = k;
        pending_cmds.push_back(c);
        if (op == OP_INSERT)
        begin
            if (live_keys.size() < TABLE_SIZE)
                live_keys.push_back(k);
        end
        else if (op == OP_DELETE)
        begin
            for (i = 0; i < live_keys.size(); i++)
            begin
                if (live_keys[i] == k)
                begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 3))
            0: k = KEY_W'($urandom());
            // short chains of colliding keys
            1: k = KEY_W'($urandom_range(0, 5) * TABLE_SIZE
                          + $urandom_range(0, TABLE_SIZE - 1));
            2: k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 40));
            // chains that wrap past the last slot
            default: k = KEY_W'($urandom_range(0, 7) * TABLE_SIZE
                                + $urandom_range(TABLE_SIZE - 3, TABLE_SIZE - 1));
        endcase
        return k;
    endfunction

    // driver: a transaction is taken when start is high and busy is low
    always @(posedge clk)
    begin : drive_cmds
        bit took;
        int idle_pct;
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            took = start && !busy;
            if (took)
            begin
                awaited_results.push_back(hash_table_apply(cmd));
                accepted_count++;
            end
            if (accepted_count * 3 < total_items)
                idle_pct = 24;
            else if (accepted_count * 3 < 2 * total_items)
                idle_pct = 49;
            else
                idle_pct = 0;
            if (!start || took)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    cmd   <= pending_cmds.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: every done cycle carries one result
    always @(posedge clk)
    begin : check_results
        out_t want;
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: status %0d position %0d",
                       result.status, result.position);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                checked_count++;
                if (result.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    mismatch_count++;
                end
                if (result.position !== want.position)
                begin
                    $error("position: expected %0d, got %0d", want.position, result.position);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int ep;
        int j;
        int len;
        int fill_bias;
        logic [1:0] op;
        logic [KEY_W-1:0] k;

        // collisions, wrap-around, duplicates and probing past an emptied slot
        queue_cmd(OP_SEARCH, '0);
        queue_cmd(OP_INSERT, '0);
        queue_cmd(OP_INSERT, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_INSERT, {KEY_W{1'b1}});
        queue_cmd(OP_INSERT, KEY_W'(2 * TABLE_SIZE - 1));
        queue_cmd(OP_SEARCH, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_UNUSED, KEY_W'(2 * TABLE_SIZE - 1));
        queue_cmd(OP_SEARCH, KEY_W'(5));
        queue_cmd(OP_DELETE, '0);
        queue_cmd(OP_SEARCH, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_INSERT, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_SEARCH, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_DELETE, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_DELETE, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_DELETE, KEY_W'(TABLE_SIZE));
        queue_cmd(OP_DELETE, {KEY_W{1'b1}});
        queue_cmd(OP_SEARCH, {KEY_W{1'b1}});
        queue_cmd(OP_DELETE, KEY_W'(2 * TABLE_SIZE - 1));
        queue_cmd(OP_INSERT, KEY_W'(31'h5555_5555));
        queue_cmd(OP_INSERT, KEY_W'(31'h2AAA_AAAA));
        queue_cmd(OP_UNUSED, KEY_W'(31'h2AAA_AAAA));
        queue_cmd(OP_DELETE, KEY_W'(31'h5555_5555));

        // episodes that either fill the table up or drain it
        for (ep = 0; pending_cmds.size() < ITEM_TARGET; ep++)
        begin
            fill_bias = $urandom_range(0, 1) ? 70 : 25;
            len = $urandom_range(20, 50);
            for (j = 0; j < len; j++)
            begin
                if ($urandom_range(0, 99) < fill_bias)
                    queue_cmd(OP_INSERT, fresh_key());
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                        op = OP_UNUSED;
                    else
                        op = $urandom_range(0, 1) ? OP_DELETE : OP_SEARCH;
                    if (live_keys.size() > 0 && $urandom_range(0, 99) < 65)
                        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                    else
                        k = fresh_key();
                    queue_cmd(op, k);
                end
            end
        end
        total_items = pending_cmds.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_count != total_items)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transactions: %0d inserts (%0d on a full table), %0d deletes,",
                 checked_count, insert_count, full_count, delete_count);
        $display("%0d searches, %0d lookups of absent keys, %0d mismatches",
                 search_count, missing_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #(4 * 400000);
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/lpht_pkg.sv
design/lpht_dp.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table_unit.sv
tb/sv/testbench.sv
